// File: rtl/ecsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ecsp_pkg;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_LBR   = 8'h5B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_RBR   = 8'h5D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int         COLOR_W  = 10;
	localparam logic [COLOR_W-1:0] DEC_BASE = COLOR_W'(10);

	// result kinds
	localparam logic KIND_CHAR  = 1'b0;
	localparam logic KIND_COLOR = 1'b1;

	// output source select
	localparam logic [1:0] OSEL_IN    = 2'd0;
	localparam logic [1:0] OSEL_COLOR = 2'd1;
	localparam logic [1:0] OSEL_PEND  = 2'd2;
	localparam logic [1:0] OSEL_HELD  = 2'd3;

	// pending buffer operations
	localparam logic [2:0] BUF_KEEP      = 3'd0;
	localparam logic [2:0] BUF_CLEAR     = 3'd1;
	localparam logic [2:0] BUF_PUSH_IN   = 3'd2;
	localparam logic [2:0] BUF_OPEN_IN   = 3'd3;
	localparam logic [2:0] BUF_OPEN_HELD = 3'd4;

	typedef struct packed {
		logic       load_out;
		logic [1:0] out_sel;
		logic       out_last;
		logic [2:0] buf_op;
		logic       acc_clear;
		logic       acc_fg;
		logic       acc_bg;
		logic       dc_clear;
		logic       dc_inc;
		logic       hold_byte;
		logic       ridx_clear;
		logic       ridx_inc;
	} ecsp_cmd_t;

	typedef struct packed {
		logic in_zero;
		logic in_esc;
		logic in_lbr;
		logic in_comma;
		logic in_rbr;
		logic in_digit;
		logic held_zero;
		logic held_esc;
		logic dc_zero;
		logic dc_full;
		logic ridx_last;
		logic out_free;
	} ecsp_status_t;

endpackage

`default_nettype wire

// File: rtl/escape_color_sequence_parser.sv
// channel   | dir | handshake            | payload
// ----------+-----+----------------------+---------------------------------------------
// s_        | in  | s_tvalid / s_tready  | s_tdata[7:0] text_byte
// m_        | out | m_tvalid / m_tready  | m_tdata char_out, fg_color, bg_color; tuser kind
//           |     |                      | tlast last
// apb       | in  | psel penable pwrite  | paddr 0: console_active (bit 0)
//
// one byte per cycle while no sequence breaks; a color result comes out on the ']'
// a broken sequence replays its buffered bytes from the pending store, one a cycle
// as the output frees, then the breaking byte unless NUL or ESC; input stalls meanwhile
// the single output register takes the next item in the cycle the previous one leaves;
// an item waiting there stalls the input
// reset (arst_n low) returns to idle with the console detached; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module escape_color_sequence_parser #(
	parameter int MAX_DIGITS = 3
) (
	input  wire         clk,
	input  wire         arst_n,
	// input bytes
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] text_byte
	// results
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [7:0] char_out, [17:8] fg_color, [27:18] bg_color
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast,
	// config port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ecsp_pkg::*;

	logic         console_q;
	logic         cfg_wr;
	ecsp_cmd_t    cmd;
	ecsp_status_t status;

	// register 0 sits at byte address 0; address 4 is outside the map
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {31'd0, console_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			console_q <= 1'b0;
		else if (cfg_wr)
			console_q <= pwdata[0];
	end

	// sequencer: parse phase, replay and tail control
	ecsp_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.console_active (console_q),
		.st             (status),
		.in_ready       (s_tready),
		.cmd            (cmd)
	);

	// accumulators, pending store and output register
	ecsp_datapath #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// File: rtl/ecsp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ecsp_datapath #(
	parameter int MAX_DIGITS = 3
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire  [7:0]            in_byte,
	input  wire  ecsp_pkg::ecsp_cmd_t    cmd,
	output ecsp_pkg::ecsp_status_t       status,
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [31:0]           m_tdata,
	output logic                  m_tuser,
	output logic                  m_tlast
);
	import ecsp_pkg::*;

	localparam int DEPTH = 2 * MAX_DIGITS + 3;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DC_W  = $clog2(MAX_DIGITS + 1);

	logic [7:0]         pend_q [DEPTH];
	logic [CNT_W-1:0]   pcnt_q;
	logic [IDX_W-1:0]   ridx_q;
	logic [7:0]         held_q;
	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;
	logic [DC_W-1:0]    dc_q;

	logic               out_valid_q;
	logic               out_kind_q;
	logic               out_last_q;
	logic [7:0]         out_char_q;
	logic [COLOR_W-1:0] out_fg_q;
	logic [COLOR_W-1:0] out_bg_q;

	logic [COLOR_W-1:0] digit_val;
	logic [7:0]         digit_off;
	logic [7:0]         sel_char;
	logic               out_free;

	assign digit_off = in_byte - CH_ZERO;
	assign digit_val = {{(COLOR_W-4){1'b0}}, digit_off[3:0]};
	assign out_free  = !out_valid_q || m_tready;

	always_comb begin
		status.in_zero   = (in_byte == CH_NUL);
		status.in_esc    = (in_byte == CH_ESC);
		status.in_lbr    = (in_byte == CH_LBR);
		status.in_comma  = (in_byte == CH_COMMA);
		status.in_rbr    = (in_byte == CH_RBR);
		status.in_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
		status.held_zero = (held_q == CH_NUL);
		status.held_esc  = (held_q == CH_ESC);
		status.dc_zero   = (dc_q == '0);
		status.dc_full   = (dc_q == DC_W'(MAX_DIGITS));
		status.ridx_last = (CNT_W'(ridx_q) == pcnt_q - CNT_W'(1));
		status.out_free  = out_free;
	end

	always_comb begin
		case (cmd.out_sel)
			OSEL_IN:   sel_char = in_byte;
			OSEL_PEND: sel_char = pend_q[ridx_q];
			OSEL_HELD: sel_char = held_q;
			default:   sel_char = CH_NUL;
		endcase
	end

	// pending byte store, no reset
	always_ff @(posedge clk) begin
		case (cmd.buf_op)
			BUF_OPEN_IN:   pend_q[0] <= in_byte;
			BUF_OPEN_HELD: pend_q[0] <= held_q;
			BUF_PUSH_IN: begin
				if (pcnt_q < CNT_W'(DEPTH))
					pend_q[pcnt_q[IDX_W-1:0]] <= in_byte;
			end
			default: ;
		endcase
		if (cmd.hold_byte)
			held_q <= in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= '0;
			ridx_q <= '0;
			fg_q   <= '0;
			bg_q   <= '0;
			dc_q   <= '0;
		end else begin
			case (cmd.buf_op)
				BUF_CLEAR:     pcnt_q <= '0;
				BUF_OPEN_IN,
				BUF_OPEN_HELD: pcnt_q <= CNT_W'(1);
				BUF_PUSH_IN: begin
					if (pcnt_q < CNT_W'(DEPTH))
						pcnt_q <= pcnt_q + CNT_W'(1);
				end
				default: ;
			endcase
			if (cmd.ridx_clear)
				ridx_q <= '0;
			else if (cmd.ridx_inc)
				ridx_q <= ridx_q + IDX_W'(1);
			if (cmd.acc_clear) begin
				fg_q <= '0;
				bg_q <= '0;
			end else if (cmd.acc_fg) begin
				fg_q <= COLOR_W'(fg_q * DEC_BASE) + digit_val;
			end else if (cmd.acc_bg) begin
				bg_q <= COLOR_W'(bg_q * DEC_BASE) + digit_val;
			end
			if (cmd.dc_clear)
				dc_q <= '0;
			else if (cmd.dc_inc)
				dc_q <= dc_q + DC_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_last_q <= cmd.out_last;
			if (cmd.out_sel == OSEL_COLOR) begin
				out_kind_q <= KIND_COLOR;
				out_char_q <= CH_NUL;
				out_fg_q   <= fg_q;
				out_bg_q   <= bg_q;
			end else begin
				out_kind_q <= KIND_CHAR;
				out_char_q <= sel_char;
				out_fg_q   <= '0;
				out_bg_q   <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'b0, out_bg_q, out_fg_q, out_char_q};

endmodule

`default_nettype wire

// File: rtl/ecsp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ecsp_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	input  wire                     console_active,
	input  wire  ecsp_pkg::ecsp_status_t st,
	output logic                    in_ready,
	output ecsp_pkg::ecsp_cmd_t     cmd
);
	import ecsp_pkg::*;

	localparam logic [1:0] ST_RUN    = 2'd0;
	localparam logic [1:0] ST_REPLAY = 2'd1;
	localparam logic [1:0] ST_TAIL   = 2'd2;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ESC  = 2'd1;
	localparam logic [1:0] PH_FG   = 2'd2;
	localparam logic [1:0] PH_BG   = 2'd3;

	logic [1:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic       accept;
	logic       brk;

	assign in_ready = (state_q == ST_RUN) && st.out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		cmd.out_sel = OSEL_IN;
		cmd.buf_op  = BUF_KEEP;
		state_d = state_q;
		phase_d = phase_q;
		brk     = 1'b0;
		case (state_q)
			ST_RUN: begin
				if (accept) begin
					if (!console_active) begin
						phase_d       = PH_IDLE;
						cmd.buf_op    = BUF_CLEAR;
						cmd.acc_clear = 1'b1;
						cmd.dc_clear  = 1'b1;
					end else begin
						case (phase_q)
							PH_ESC: begin
								if (st.in_lbr) begin
									cmd.buf_op    = BUF_PUSH_IN;
									cmd.acc_clear = 1'b1;
									cmd.dc_clear  = 1'b1;
									phase_d       = PH_FG;
								end else begin
									brk = 1'b1;
								end
							end
							PH_FG, PH_BG: begin
								if (st.in_digit && !st.dc_full) begin
									cmd.buf_op = BUF_PUSH_IN;
									cmd.acc_fg = (phase_q == PH_FG);
									cmd.acc_bg = (phase_q == PH_BG);
									cmd.dc_inc = 1'b1;
								end else if (phase_q == PH_FG && st.in_comma && !st.dc_zero) begin
									cmd.buf_op   = BUF_PUSH_IN;
									cmd.dc_clear = 1'b1;
									phase_d      = PH_BG;
								end else if (phase_q == PH_BG && st.in_rbr && !st.dc_zero) begin
									cmd.load_out  = 1'b1;
									cmd.out_sel   = OSEL_COLOR;
									cmd.out_last  = 1'b1;
									cmd.buf_op    = BUF_CLEAR;
									cmd.acc_clear = 1'b1;
									cmd.dc_clear  = 1'b1;
									phase_d       = PH_IDLE;
								end else begin
									brk = 1'b1;
								end
							end
							default: begin
								if (st.in_esc) begin
									cmd.buf_op = BUF_OPEN_IN;
									phase_d    = PH_ESC;
								end else if (!st.in_zero) begin
									cmd.load_out = 1'b1;
									cmd.out_sel  = OSEL_IN;
									cmd.out_last = 1'b1;
								end
							end
						endcase
						// broken sequence: keep the byte, replay the buffer
						if (brk) begin
							cmd.hold_byte  = 1'b1;
							cmd.ridx_clear = 1'b1;
							state_d        = ST_REPLAY;
						end
					end
				end
			end
			ST_REPLAY: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = OSEL_PEND;
					cmd.out_last = st.ridx_last && (st.held_zero || st.held_esc);
					cmd.ridx_inc = 1'b1;
					if (st.ridx_last) begin
						cmd.acc_clear = 1'b1;
						cmd.dc_clear  = 1'b1;
						if (st.held_esc) begin
							cmd.buf_op = BUF_OPEN_HELD;
							phase_d    = PH_ESC;
						end else begin
							cmd.buf_op = BUF_CLEAR;
							phase_d    = PH_IDLE;
						end
						state_d = (st.held_zero || st.held_esc) ? ST_RUN : ST_TAIL;
					end
				end
			end
			ST_TAIL: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = OSEL_HELD;
					cmd.out_last = 1'b1;
					state_d      = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			phase_q <= PH_IDLE;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// the tail stage only ever prints a plain byte
	a_tail_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAIL) |-> (!st.held_zero && !st.held_esc))
		else $error("tail stage holds a terminator or escape");

	// replay leaves once the last buffered byte is out
	a_replay_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPLAY && st.out_free && st.ridx_last) |=> (state_q != ST_REPLAY))
		else $error("replay did not end after last buffered byte");

	// a replay starts only from an open sequence
	a_replay_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && state_d == ST_REPLAY) |-> (phase_q != PH_IDLE))
		else $error("replay started without an open sequence");

	// no input is taken while replay or tail is running
	a_input_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |-> !in_ready)
		else $error("input taken during replay");

endmodule

`default_nettype wire
